@@ rtl/assert_macros.svh @@
// assertion macros used by the rtl controller module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked on every clock edge out of reset
`define ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("implication check failed");

// next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

@@ rtl/mkdt_pkg.sv @@
// types, codes and constants of the device table
`default_nettype none
package mkdt_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int COUNT_W     = $clog2(TABLE_DEPTH + 1);

    // apb register map
    localparam int             PADDR_W             = 3;
    localparam logic [0:0]     REG_OFFLINE_TIMEOUT = 1'b0;
    localparam logic [31:0]    TIMEOUT_RESET       = 32'd300;

    localparam logic [7:0]     BATTERY_UNKNOWN = 8'd255;
    localparam logic [9:0]     HUMIDITY_MAX    = 10'd1000;

    // operation codes
    localparam logic [2:0] OP_ADD      = 3'd0;
    localparam logic [2:0] OP_REMOVE   = 3'd1;
    localparam logic [2:0] OP_SEEN     = 3'd2;
    localparam logic [2:0] OP_READINGS = 3'd3;
    localparam logic [2:0] OP_QUERY    = 3'd4;
    localparam logic [2:0] OP_TIMEOUTS = 3'd5;
    localparam logic [2:0] OP_CLEAR    = 3'd6;

    // result status codes
    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_NOT_FOUND = 2'd1;
    localparam logic [1:0] STAT_FULL      = 2'd2;

    typedef struct packed {
        logic [2:0]         func;
        logic [47:0]        mac;
        logic [7:0]         type_code;
        logic signed [7:0]  rssi;
        logic [7:0]         moisture;
        logic signed [15:0] temperature;
        logic               temperature_valid;
        logic [9:0]         humidity;
        logic               humidity_valid;
        logic [7:0]         battery;
        logic [31:0]        now_seconds;
    } item_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [COUNT_W-1:0] online_count;
        logic [7:0]         entry_type;
        logic               entry_online;
        logic [31:0]        entry_last_seen;
        logic signed [7:0]  entry_rssi;
        logic [7:0]         entry_moisture;
        logic signed [15:0] entry_temperature;
        logic [9:0]         entry_humidity;
        logic [7:0]         entry_battery;
    } result_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic write;
        logic respond;
    } cmd_t;

endpackage
`default_nettype wire

@@ rtl/mkdt_ctrl.sv @@
// controller state machine: accept, write-back, respond
`default_nettype none
`include "assert_macros.svh"
module mkdt_ctrl
    import mkdt_pkg::*;
(
    input  wire   aclk,
    input  wire   aresetn,
    input  wire   s_tvalid,
    output logic  s_tready,
    output logic  m_tvalid,
    input  wire   m_tready,
    output cmd_t  cmd
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_WRITE = 2'd1;
    localparam logic [1:0] ST_RESP  = 2'd2;

    logic [1:0] state_reg, state_next;
    logic       m_tvalid_reg, m_tvalid_next;
    logic       s_accept;
    logic       out_free;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign m_tvalid = m_tvalid_reg;

    always_comb begin
        state_next  = state_reg;
        cmd.load    = 1'b0;
        cmd.write   = 1'b0;
        cmd.respond = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    cmd.load   = 1'b1;
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE: begin
                cmd.write  = 1'b1;
                state_next = ST_RESP;
            end
            ST_RESP: begin
                // hold the finished item until the output register is free
                if (out_free) begin
                    cmd.respond = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (cmd.respond) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    `ASSERT_NEXT(a_accept_then_write, s_accept, cmd.write)
    `ASSERT_NEXT(a_write_then_respond_state, cmd.write, state_reg == ST_RESP)
    `ASSERT_IMPL(a_respond_no_overwrite, cmd.respond, !m_tvalid_reg || m_tready)
    `ASSERT_NEXT(a_respond_shows_valid, cmd.respond, m_tvalid_reg)

endmodule
`default_nettype wire

@@ rtl/mkdt_datapath.sv @@
// slot table, parallel address match, write-back and result register
`default_nettype none
module mkdt_datapath
    import mkdt_pkg::*;
(
    input  wire          aclk,
    input  wire          aresetn,
    input  wire cmd_t    cmd,
    input  wire item_t   item,
    input  wire  [31:0]  offline_timeout,
    output result_t      result
);

    logic [TABLE_DEPTH-1:0] slot_valid_reg;
    logic [47:0]            slot_addr_reg     [TABLE_DEPTH];
    logic [7:0]             slot_type_reg     [TABLE_DEPTH];
    logic                   slot_online_reg   [TABLE_DEPTH];
    logic [31:0]            slot_seen_reg     [TABLE_DEPTH];
    logic [7:0]             slot_signal_reg   [TABLE_DEPTH];
    logic [7:0]             slot_moisture_reg [TABLE_DEPTH];
    logic [15:0]            slot_temp_reg     [TABLE_DEPTH];
    logic [9:0]             slot_hum_reg      [TABLE_DEPTH];
    logic [7:0]             slot_battery_reg  [TABLE_DEPTH];

    item_t                  item_reg;
    logic [1:0]             stat_reg, stat_next;
    logic [IDX_W-1:0]       idx_reg, idx_next;
    logic                   show_reg, show_next;
    logic                   new_reg;
    result_t                result_reg, result_next;

    logic [TABLE_DEPTH-1:0] match;
    logic                   found, has_free;
    logic [IDX_W-1:0]       hit_idx, free_idx;
    logic [COUNT_W-1:0]     online_cnt;
    logic [9:0]             hum_sat;

    // address compare in every slot, lowest hit wins
    always_comb begin
        found    = 1'b0;
        has_free = 1'b0;
        hit_idx  = '0;
        free_idx = '0;
        for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
            match[i] = slot_valid_reg[i] && (slot_addr_reg[i] == item.mac);
            if (match[i]) begin
                found   = 1'b1;
                hit_idx = IDX_W'(i);
            end
            if (!slot_valid_reg[i]) begin
                has_free = 1'b1;
                free_idx = IDX_W'(i);
            end
        end
    end

    always_comb begin
        stat_next = STAT_OK;
        idx_next  = hit_idx;
        show_next = 1'b0;
        unique case (item.func) inside
            OP_ADD: begin
                if (!found) begin
                    idx_next = free_idx;
                end
                if (!found && !has_free) begin
                    stat_next = STAT_FULL;
                end else begin
                    show_next = 1'b1;
                end
            end
            OP_REMOVE: begin
                if (!found) begin
                    stat_next = STAT_NOT_FOUND;
                end
            end
            OP_SEEN, OP_READINGS, OP_QUERY: begin
                if (!found) begin
                    stat_next = STAT_NOT_FOUND;
                end else begin
                    show_next = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            item_reg <= item;
            stat_reg <= stat_next;
            idx_reg  <= idx_next;
            show_reg <= show_next;
            new_reg  <= !found;
        end
    end

    assign hum_sat = (item_reg.humidity > HUMIDITY_MAX) ? HUMIDITY_MAX : item_reg.humidity;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_valid_reg <= '0;
        end else if (cmd.write) begin
            case (item_reg.func)
                OP_ADD: begin
                    if (stat_reg == STAT_OK) begin
                        slot_valid_reg[idx_reg] <= 1'b1;
                    end
                end
                OP_REMOVE: begin
                    if (stat_reg == STAT_OK) begin
                        slot_valid_reg[idx_reg] <= 1'b0;
                    end
                end
                OP_CLEAR: slot_valid_reg <= '0;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.write) begin
            case (item_reg.func)
                OP_ADD: begin
                    if (stat_reg == STAT_OK) begin
                        slot_type_reg[idx_reg]   <= item_reg.type_code;
                        slot_online_reg[idx_reg] <= 1'b1;
                        slot_seen_reg[idx_reg]   <= item_reg.now_seconds;
                        if (new_reg) begin
                            slot_addr_reg[idx_reg]     <= item_reg.mac;
                            slot_signal_reg[idx_reg]   <= '0;
                            slot_moisture_reg[idx_reg] <= '0;
                            slot_temp_reg[idx_reg]     <= '0;
                            slot_hum_reg[idx_reg]      <= '0;
                            slot_battery_reg[idx_reg]  <= '0;
                        end
                    end
                end
                OP_SEEN: begin
                    if (stat_reg == STAT_OK) begin
                        slot_seen_reg[idx_reg]   <= item_reg.now_seconds;
                        slot_signal_reg[idx_reg] <= item_reg.rssi;
                        slot_online_reg[idx_reg] <= 1'b1;
                    end
                end
                OP_READINGS: begin
                    if (stat_reg == STAT_OK) begin
                        slot_moisture_reg[idx_reg] <= item_reg.moisture;
                        if (item_reg.temperature_valid) begin
                            slot_temp_reg[idx_reg] <= item_reg.temperature;
                        end
                        if (item_reg.humidity_valid) begin
                            slot_hum_reg[idx_reg] <= hum_sat;
                        end
                        if (item_reg.battery != BATTERY_UNKNOWN) begin
                            slot_battery_reg[idx_reg] <= item_reg.battery;
                        end
                    end
                end
                OP_TIMEOUTS: begin
                    // age is a wrapping 32-bit difference, checked per slot
                    for (int i = 0; i < TABLE_DEPTH; i++) begin
                        if (slot_valid_reg[i] && slot_online_reg[i] &&
                            ((item_reg.now_seconds - slot_seen_reg[i]) > offline_timeout)) begin
                            slot_online_reg[i] <= 1'b0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        online_cnt = '0;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            online_cnt = online_cnt + COUNT_W'(slot_valid_reg[i] && slot_online_reg[i]);
        end
    end

    always_comb begin
        result_next              = '0;
        result_next.status       = stat_reg;
        result_next.online_count = online_cnt;
        if (show_reg) begin
            result_next.entry_type        = slot_type_reg[idx_reg];
            result_next.entry_online      = slot_online_reg[idx_reg];
            result_next.entry_last_seen   = slot_seen_reg[idx_reg];
            result_next.entry_rssi        = slot_signal_reg[idx_reg];
            result_next.entry_moisture    = slot_moisture_reg[idx_reg];
            result_next.entry_temperature = slot_temp_reg[idx_reg];
            result_next.entry_humidity    = slot_hum_reg[idx_reg];
            result_next.entry_battery     = slot_battery_reg[idx_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.respond) begin
            result_reg <= result_next;
        end
    end

    assign result = result_reg;

endmodule
`default_nettype wire

@@ rtl/mac_keyed_device_table_with_aging_top.sv @@
// top level: stream ports, apb register and the table core
// Device table of TABLE_DEPTH (16) entries keyed by a 48-bit MAC address, with
// online/offline aging. Each input item carries an operation in s_tuser and
// yields exactly one result item with the status in m_tuser. After it is accepted,
// an item first writes the updated entry back into the slot registers and then
// reads the record and counts online entries into the output register; that
// second step is held while an earlier result still waits on m_tready. A new
// item is accepted again on the cycle after that, also while the previous
// result still waits on m_tready. The address match over all slots is done on
// the cycle of acceptance. The offline timeout register sits at byte address 0
// of the apb port and resets to 300 seconds.
`default_nettype none
module mac_keyed_device_table_with_aging_top
    import mkdt_pkg::*;
(
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 s_tvalid,
    output logic                s_tready,
    // mac, type_code, rssi, moisture, temperature, temperature_valid,
    // humidity, humidity_valid, battery, now_seconds, zero pad
    input  wire  [143:0]        s_tdata,
    // func
    input  wire  [2:0]          s_tuser,
    output logic                m_tvalid,
    input  wire                 m_tready,
    // online_count, entry_type, entry_online, entry_last_seen, entry_rssi,
    // entry_moisture, entry_temperature, entry_humidity, entry_battery
    output logic [95:0]         m_tdata,
    // status
    output logic [1:0]          m_tuser,
    input  wire                 psel,
    input  wire                 penable,
    input  wire                 pwrite,
    input  wire  [PADDR_W-1:0]  paddr,
    input  wire  [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    logic [31:0] timeout_reg;
    logic        reg_sel;
    item_t       item;
    result_t     result;
    cmd_t        cmd;

    assign pready  = 1'b1;
    assign reg_sel = (paddr[PADDR_W-1:2] == REG_OFFLINE_TIMEOUT);
    assign prdata  = reg_sel ? timeout_reg : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeout_reg <= TIMEOUT_RESET;
        end else if (psel && penable && pwrite && pready && reg_sel) begin
            timeout_reg <= pwdata;
        end
    end

    assign item.func              = s_tuser;
    assign item.mac               = s_tdata[47:0];
    assign item.type_code         = s_tdata[55:48];
    assign item.rssi              = s_tdata[63:56];
    assign item.moisture          = s_tdata[71:64];
    assign item.temperature       = s_tdata[87:72];
    assign item.temperature_valid = s_tdata[88];
    assign item.humidity          = s_tdata[98:89];
    assign item.humidity_valid    = s_tdata[99];
    assign item.battery           = s_tdata[107:100];
    assign item.now_seconds       = s_tdata[139:108];

    assign m_tuser = result.status;
    assign m_tdata = {result.entry_battery, result.entry_humidity,
                      result.entry_temperature, result.entry_moisture,
                      result.entry_rssi, result.entry_last_seen,
                      result.entry_online, result.entry_type,
                      result.online_count};

    mkdt_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    mkdt_datapath u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .item            (item),
        .offline_timeout (timeout_reg),
        .result          (result)
    );

endmodule
`default_nettype wire

@@ tb/mac_keyed_device_table_with_aging_top_tb.sv @@
// self-checking testbench for the mac-keyed device table with aging
`timescale 1ns / 1ps
module mac_keyed_device_table_with_aging_top_tb;
    import mkdt_pkg::*;

    localparam logic [2:0]         OP_UNUSED    = 3'd7;
    localparam logic [PADDR_W-1:0] TIMEOUT_ADDR = {REG_OFFLINE_TIMEOUT, 2'b00};
    localparam logic [PADDR_W-1:0] SPARE_ADDR   = 3'd4;
    localparam int                 POOL_SIZE    = 20;
    localparam int                 PHASE_ITEMS  = 180;
    localparam int                 FILL_COUNT   = 14;
    localparam longint             LIMIT_NS     = 3_000_000;

    typedef struct {
        item_t   stim;
        bit      typed;
        result_t want;
    } step_row_t;

    logic                aclk = 1'b0;
    logic                aresetn;
    logic                s_tvalid;
    wire                 s_tready;
    logic [143:0]        s_tdata;
    logic [2:0]          s_tuser;
    wire                 m_tvalid;
    logic                m_tready = 1'b0;
    wire  [95:0]         m_tdata;
    wire  [1:0]          m_tuser;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [31:0]         pwdata;
    wire  [31:0]         prdata;
    wire                 pready;

    // predicted table contents
    logic               dev_valid [TABLE_DEPTH];
    logic [47:0]        dev_mac [TABLE_DEPTH];
    logic [7:0]         dev_type [TABLE_DEPTH];
    logic               dev_online [TABLE_DEPTH];
    logic [31:0]        dev_seen [TABLE_DEPTH];
    logic [7:0]         dev_rssi [TABLE_DEPTH];
    logic [7:0]         dev_moisture [TABLE_DEPTH];
    logic [15:0]        dev_temp [TABLE_DEPTH];
    logic [9:0]         dev_humidity [TABLE_DEPTH];
    logic [7:0]         dev_battery [TABLE_DEPTH];
    logic [31:0]        offline_limit;

    result_t            awaited_records [$];
    step_row_t          plan_rows [$];
    logic [47:0]        mac_pool [POOL_SIZE];
    logic [31:0]        wall_clock;
    int                 mismatches = 0;
    int                 hold_cycles = 0;
    bit                 steady = 1'b0;

    mac_keyed_device_table_with_aging_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    initial begin
        #(LIMIT_NS);
        $display("[mac_keyed_device_table_with_aging_top] ERROR");
        $finish;
    end

    function automatic item_t make_item(logic [2:0] func, logic [47:0] mac, logic [7:0] dtype,
                                        logic [7:0] rssi, logic [7:0] moist, logic [15:0] temp,
                                        logic temp_ok, logic [9:0] hum, logic hum_ok,
                                        logic [7:0] batt, logic [31:0] now);
        item_t it;
        it.func              = func;
        it.mac               = mac;
        it.type_code         = dtype;
        it.rssi              = rssi;
        it.moisture          = moist;
        it.temperature       = temp;
        it.temperature_valid = temp_ok;
        it.humidity          = hum;
        it.humidity_valid    = hum_ok;
        it.battery           = batt;
        it.now_seconds       = now;
        return it;
    endfunction

    function automatic result_t make_record(logic [1:0] st, logic [COUNT_W-1:0] cnt,
                                            logic [7:0] dtype, logic online, logic [31:0] last,
                                            logic [7:0] rssi, logic [7:0] moist,
                                            logic [15:0] temp, logic [9:0] hum,
                                            logic [7:0] batt);
        result_t rec;
        rec.status            = st;
        rec.online_count      = cnt;
        rec.entry_type        = dtype;
        rec.entry_online      = online;
        rec.entry_last_seen   = last;
        rec.entry_rssi        = rssi;
        rec.entry_moisture    = moist;
        rec.entry_temperature = temp;
        rec.entry_humidity    = hum;
        rec.entry_battery     = batt;
        return rec;
    endfunction

    function automatic void add_row(item_t stim, bit typed, result_t want);
        step_row_t row;
        row.stim  = stim;
        row.typed = typed;
        row.want  = want;
        plan_rows.insert(plan_rows.size(), row);
    endfunction

    function automatic logic [143:0] pack_request(item_t it);
        return {4'b0, it.now_seconds, it.battery, it.humidity_valid, it.humidity,
                it.temperature_valid, it.temperature, it.moisture, it.rssi,
                it.type_code, it.mac};
    endfunction

    function automatic result_t unpack_record(logic [95:0] d, logic [1:0] st);
        return make_record(st, d[4:0], d[12:5], d[13], d[45:14], d[53:46], d[61:54],
                           d[77:62], d[87:78], d[95:88]);
    endfunction

    function automatic int find_slot(logic [47:0] mac);
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            if (dev_valid[i] && dev_mac[i] == mac) return i;
        end
        return -1;
    endfunction

    // one table operation on the predicted state, giving the record it should return
    task automatic apply_table_op(input item_t it, output result_t rec);
        int                 hit;
        int                 gone;
        logic [COUNT_W-1:0] cnt;
        logic [1:0]         st;
        logic [31:0]        age;
        hit = -1;
        st  = STAT_OK;
        case (it.func)
            OP_ADD: begin
                hit = find_slot(it.mac);
                if (hit < 0) begin
                    for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
                        if (!dev_valid[i]) hit = i;
                    end
                    if (hit < 0) begin
                        st = STAT_FULL;
                    end else begin
                        dev_valid[hit]    = 1'b1;
                        dev_mac[hit]      = it.mac;
                        dev_rssi[hit]     = '0;
                        dev_moisture[hit] = '0;
                        dev_temp[hit]     = '0;
                        dev_humidity[hit] = '0;
                        dev_battery[hit]  = '0;
                    end
                end
                if (hit >= 0) begin
                    dev_type[hit]   = it.type_code;
                    dev_online[hit] = 1'b1;
                    dev_seen[hit]   = it.now_seconds;
                end
            end
            OP_REMOVE: begin
                gone = find_slot(it.mac);
                if (gone < 0) st = STAT_NOT_FOUND;
                else dev_valid[gone] = 1'b0;
            end
            OP_SEEN, OP_READINGS, OP_QUERY: begin
                hit = find_slot(it.mac);
                if (hit < 0) begin
                    st = STAT_NOT_FOUND;
                end else if (it.func == OP_SEEN) begin
                    dev_seen[hit]   = it.now_seconds;
                    dev_rssi[hit]   = it.rssi;
                    dev_online[hit] = 1'b1;
                end else if (it.func == OP_READINGS) begin
                    dev_moisture[hit] = it.moisture;
                    if (it.temperature_valid) dev_temp[hit] = it.temperature;
                    if (it.humidity_valid) begin
                        dev_humidity[hit] = (it.humidity > HUMIDITY_MAX) ? HUMIDITY_MAX
                                                                         : it.humidity;
                    end
                    if (it.battery != BATTERY_UNKNOWN) dev_battery[hit] = it.battery;
                end
            end
            OP_TIMEOUTS: begin
                for (int i = 0; i < TABLE_DEPTH; i++) begin
                    age = it.now_seconds - dev_seen[i];
                    if (dev_valid[i] && dev_online[i] && age > offline_limit) begin
                        dev_online[i] = 1'b0;
                    end
                end
            end
            OP_CLEAR: begin
                for (int i = 0; i < TABLE_DEPTH; i++) dev_valid[i] = 1'b0;
            end
            default: ;
        endcase
        cnt = '0;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            if (dev_valid[i] && dev_online[i]) cnt = cnt + 1'b1;
        end
        rec = '0;
        rec.status       = st;
        rec.online_count = cnt;
        if (st == STAT_OK && hit >= 0) begin
            rec = make_record(st, cnt, dev_type[hit], dev_online[hit], dev_seen[hit],
                              dev_rssi[hit], dev_moisture[hit], dev_temp[hit],
                              dev_humidity[hit], dev_battery[hit]);
        end
    endtask

    function automatic bit field_off(string name, logic [31:0] want, logic [31:0] got,
                                     bit loud);
        if (want !== got) begin
            if (loud) $display("  %s: expected %h, got %h", name, want, got);
            return 1'b1;
        end
        return 1'b0;
    endfunction

    task automatic check_record(result_t want, result_t got);
        bit loud;
        bit bad;
        loud = (mismatches < 10);
        if (loud && want !== got) $display("result mismatch at %0t", $realtime);
        bad = 1'b0;
        bad |= field_off("status", want.status, got.status, loud);
        bad |= field_off("online_count", want.online_count, got.online_count, loud);
        bad |= field_off("entry_type", want.entry_type, got.entry_type, loud);
        bad |= field_off("entry_online", want.entry_online, got.entry_online, loud);
        bad |= field_off("entry_last_seen", want.entry_last_seen, got.entry_last_seen, loud);
        bad |= field_off("entry_rssi", want.entry_rssi, got.entry_rssi, loud);
        bad |= field_off("entry_moisture", want.entry_moisture, got.entry_moisture, loud);
        bad |= field_off("entry_temperature", want.entry_temperature,
                         got.entry_temperature, loud);
        bad |= field_off("entry_humidity", want.entry_humidity, got.entry_humidity, loud);
        bad |= field_off("entry_battery", want.entry_battery, got.entry_battery, loud);
        if (bad) mismatches++;
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (awaited_records.size() == 0) begin
                if (mismatches < 10) begin
                    $display("unexpected result item: status %h data %h", m_tuser, m_tdata);
                end
                mismatches++;
            end else begin
                check_record(awaited_records.pop_front(), unpack_record(m_tdata, m_tuser));
            end
        end
    end

    // receiver: random back-pressure, or a long hold-off when asked for
    always @(negedge aclk) begin
        if (hold_cycles > 0) begin
            m_tready <= 1'b0;
            hold_cycles = hold_cycles - 1;
        end else if (!steady && $urandom_range(99) < 38) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // called at a falling edge, returns at a falling edge with nothing driven there
    task automatic offer_item(item_t it, bit typed, result_t want);
        result_t predicted;
        while (!steady && $urandom_range(99) < 38) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= pack_request(it);
        s_tuser  <= it.func;
        do @(posedge aclk); while (!s_tready);
        apply_table_op(it, predicted);
        awaited_records.insert(awaited_records.size(), typed ? want : predicted);
        @(negedge aclk);
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        while (awaited_records.size() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic apb_write(logic [PADDR_W-1:0] addr, logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (addr == TIMEOUT_ADDR) offline_limit = data;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic apb_read_check(logic [PADDR_W-1:0] addr, logic [31:0] want);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (prdata !== want) begin
            if (mismatches < 10) $display("register read: expected %h, got %h", want, prdata);
            mismatches++;
        end
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge aclk);
    endtask

    function automatic item_t random_item();
        item_t       it;
        int unsigned pick;
        logic [2:0]  func;
        logic [47:0] mac;
        logic [9:0]  hum;
        logic [7:0]  batt;
        pick = $urandom_range(99);
        if (pick < 26)      func = OP_ADD;
        else if (pick < 43) func = OP_SEEN;
        else if (pick < 61) func = OP_READINGS;
        else if (pick < 75) func = OP_QUERY;
        else if (pick < 85) func = OP_REMOVE;
        else if (pick < 96) func = OP_TIMEOUTS;
        else if (pick < 98) func = OP_CLEAR;
        else                func = OP_UNUSED;
        mac = ($urandom_range(9) == 0) ? 48'({$urandom, $urandom})
                                       : mac_pool[$urandom_range(POOL_SIZE-1)];
        // mostly a clock that creeps forward, sometimes back or anywhere
        pick = $urandom_range(99);
        if (pick < 88)      wall_clock = wall_clock + $urandom_range(120);
        else if (pick < 95) wall_clock = wall_clock - $urandom_range(50);
        else                wall_clock = $urandom;
        hum  = ($urandom_range(99) < 85) ? 10'($urandom_range(1000))
                                         : 10'($urandom_range(1023, 1001));
        batt = ($urandom_range(9) == 0) ? BATTERY_UNKNOWN : 8'($urandom);
        it = make_item(func, mac, 8'($urandom), 8'($urandom), 8'($urandom), 16'($urandom),
                       $urandom_range(3) != 0, hum, $urandom_range(3) != 0, batt, wall_clock);
        return it;
    endfunction

    initial begin
        logic [31:0] limits [5];
        logic [47:0] ones;
        item_t       stim;

        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = '0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        offline_limit = TIMEOUT_RESET;
        wall_clock    = 32'd1000;
        for (int i = 0; i < TABLE_DEPTH; i++) dev_valid[i] = 1'b0;
        ones = '1;

        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        apb_read_check(TIMEOUT_ADDR, TIMEOUT_RESET);

        // directed: empty table, extremes, saturation, no-value readings, ageing, full table
        add_row(make_item(OP_QUERY, 48'h0000_0000_0abc, 0, 0, 0, 0, 1, 0, 1, 0, 0),
                1, make_record(STAT_NOT_FOUND, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        add_row(make_item(OP_ADD, '0, 0, 0, 0, 0, 0, 0, 0, 0, 0),
                1, make_record(STAT_OK, 1, 0, 1, 0, 0, 0, 0, 0, 0));
        add_row(make_item(OP_ADD, ones, 8'hff, 8'h7f, 8'hff, 16'h7fff, 1, 10'h3ff, 1,
                          8'hff, 32'hffff_ffff),
                1, make_record(STAT_OK, 2, 8'hff, 1, 32'hffff_ffff, 0, 0, 0, 0, 0));
        add_row(make_item(OP_READINGS, ones, 0, 0, 8'hff, 16'h8000, 1, 10'h3ff, 1,
                          8'hfe, 0),
                1, make_record(STAT_OK, 2, 8'hff, 1, 32'hffff_ffff, 0, 8'hff,
                               16'h8000, HUMIDITY_MAX, 8'hfe));
        add_row(make_item(OP_READINGS, ones, 0, 0, 8'h00, 16'h7fff, 0, 10'h155, 0,
                          BATTERY_UNKNOWN, 0), 0, '0);
        add_row(make_item(OP_SEEN, '0, 0, 8'h80, 0, 0, 0, 0, 0, 0, 32'd100), 0, '0);
        add_row(make_item(OP_ADD, '0, 8'h5a, 0, 0, 0, 0, 0, 0, 0, 32'd150), 0, '0);
        // wrapped age of the all-ones entry exceeds the reset limit
        add_row(make_item(OP_TIMEOUTS, '0, 0, 0, 0, 0, 0, 0, 0, 0, 32'd301), 0, '0);
        add_row(make_item(OP_UNUSED, '0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0, '0);
        for (int i = 0; i < FILL_COUNT; i++) begin
            add_row(make_item(OP_ADD, {8'h5a, 36'h0, 4'(i)}, 8'(i), 0, 0, 0, 0, 0, 0,
                              0, 32'(400 + i)), 0, '0);
        end
        add_row(make_item(OP_ADD, 48'h1234_5678_9abc, 8'h11, 0, 0, 0, 0, 0, 0, 0,
                          32'd500), 0, '0);
        add_row(make_item(OP_REMOVE, ones, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0, '0);
        add_row(make_item(OP_QUERY, ones, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0, '0);
        add_row(make_item(OP_CLEAR, '0, 0, 0, 0, 0, 0, 0, 0, 0, 0),
                1, make_record(STAT_OK, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        foreach (plan_rows[k]) offer_item(plan_rows[k].stim, plan_rows[k].typed, plan_rows[k].want);
        settle();

        limits[0] = 32'hffff_ffff;
        limits[1] = 32'd0;
        limits[2] = TIMEOUT_RESET;
        limits[3] = $urandom_range(1000, 1);
        limits[4] = $urandom;
        for (int phase = 0; phase < 5; phase++) begin
            if (phase == 2) apb_write(SPARE_ADDR, $urandom);
            apb_write(TIMEOUT_ADDR, limits[phase]);
            apb_read_check(TIMEOUT_ADDR, offline_limit);
            steady = (phase == 1);
            for (int i = 0; i < POOL_SIZE; i++) mac_pool[i] = 48'({$urandom, $urandom});
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // long hold-off on the result side so the input backs up
                if (phase == 3 && n == 20) hold_cycles = 60;
                if (phase == 3 && n == 120) settle();
                stim = random_item();
                offer_item(stim, 1'b0, '0);
            end
            settle();
        end

        repeat (10) @(posedge aclk);
        if (mismatches == 0) begin
            $display("[mac_keyed_device_table_with_aging_top] OK");
        end else begin
            $display("[mac_keyed_device_table_with_aging_top] ERROR");
        end
        $finish;
    end

endmodule
